@@ src/fixed_window_rate_limiter_assert.svh @@
// Assertion macros for the fixed-window rate limiter.
// Included by the modules that check their own logic; no other dependencies.
`ifndef FIXED_WINDOW_RATE_LIMITER_ASSERT_SVH
`define FIXED_WINDOW_RATE_LIMITER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define FWRL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the following cycle
`define FWRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FWRL_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define FWRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ src/fwrl_pkg.sv @@
// Shared types and constants of the fixed-window rate limiter.
// Used by the controller, the datapath and the top level; no dependencies.
package fwrl_pkg;

  localparam int KEYS_PER_RULE = 64;
  localparam int RULE_TYPES    = 2;
  localparam int ENTRIES       = RULE_TYPES * KEYS_PER_RULE;
  localparam int IDX_W         = $clog2(ENTRIES);

  localparam int REQ_W   = 2;
  localparam int RULE_W  = 1;
  localparam int KEY_W   = 6;
  localparam int CNT_W   = 16;
  localparam int WIN_W   = 31;
  localparam int TICK_W  = 32;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CHECK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMITER_OFF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_REGISTERED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT_0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS_0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT_1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS_1 = 3'd5;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic [TICK_W-1:0] start;
    logic [CNT_W-1:0]  count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

@@ src/fwrl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Holds the per-entry count and window start; no dependencies.
module fwrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fwrl_ctrl.sv @@
// Sequencer of the rate limiter: accept, entry read, execute/write back.
// Depends on fwrl_pkg and the assertion macro header.
`include "fixed_window_rate_limiter_assert.svh"

module fwrl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  fwrl_pkg::sts_t sts,
  output fwrl_pkg::cmd_t cmd
);

  fwrl_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      fwrl_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = fwrl_pkg::ST_READ;
        end
      end
      fwrl_pkg::ST_READ: begin
        // RAM read of the latched index is in flight
        state_next = fwrl_pkg::ST_EXEC;
      end
      fwrl_pkg::ST_EXEC: begin
        // wait while an earlier result still sits in the output register
        if (!sts.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = fwrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fwrl_pkg::ST_IDLE;
      end
    endcase
  end

  `FWRL_ASSERT_NEXT(a_load_to_read, clk, rst, cmd.load, state == fwrl_pkg::ST_READ, "load did not enter read")
  `FWRL_ASSERT_NEXT(a_read_to_exec, clk, rst, state == fwrl_pkg::ST_READ, state == fwrl_pkg::ST_EXEC, "read did not enter exec")
  `FWRL_ASSERT_SAME(a_exec_free, clk, rst, cmd.exec, !sts.out_busy, "exec while output register busy")

endmodule

@@ src/fwrl_dpath.sv @@
// Datapath of the rate limiter: config registers, tick counter, valid bits,
// entry RAM, window check and output register. Depends on fwrl_pkg, fwrl_ram.
`include "fixed_window_rate_limiter_assert.svh"

module fwrl_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  fwrl_pkg::cmd_t                      cmd,
  output fwrl_pkg::sts_t                      sts,
  input  logic [7:0]                          s_tdata,
  input  logic [2:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,
  input  logic                                cfg_we,
  input  logic [fwrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fwrl_pkg::CFG_W-1:0]          cfg_data
);

  // configuration
  logic                           limiter_off;
  logic [fwrl_pkg::RULE_TYPES-1:0] rule_registered;
  logic [fwrl_pkg::CNT_W-1:0]     max_count_0, max_count_1;
  logic [fwrl_pkg::WIN_W-1:0]     window_ticks_0, window_ticks_1;

  // state
  logic [fwrl_pkg::TICK_W-1:0]    tick_now;
  logic [fwrl_pkg::ENTRIES-1:0]   entry_valid;

  // latched item
  logic [fwrl_pkg::REQ_W-1:0]     req;
  logic [fwrl_pkg::RULE_W-1:0]    rule;
  logic [fwrl_pkg::KEY_W-1:0]     key;

  // output register
  logic                           limited_q, enabled_q;

  // RAM side
  logic                           ram_we;
  fwrl_pkg::entry_t               ram_wdata, ram_rdata;
  logic [fwrl_pkg::IDX_W-1:0]     idx;

  // decode
  logic                           enabled, key_ok, act, limited;
  logic [fwrl_pkg::CNT_W-1:0]     maxc;
  logic [fwrl_pkg::WIN_W-1:0]     win;
  logic [fwrl_pkg::TICK_W-1:0]    age;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_off     <= 1'b0;
      rule_registered <= '0;
      max_count_0     <= '0;
      max_count_1     <= '0;
      window_ticks_0  <= fwrl_pkg::WIN_W'(1);
      window_ticks_1  <= fwrl_pkg::WIN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        fwrl_pkg::CFG_LIMITER_OFF:     limiter_off     <= cfg_data[0];
        fwrl_pkg::CFG_RULE_REGISTERED: rule_registered <= cfg_data[fwrl_pkg::RULE_TYPES-1:0];
        fwrl_pkg::CFG_MAX_COUNT_0:     max_count_0     <= cfg_data[fwrl_pkg::CNT_W-1:0];
        fwrl_pkg::CFG_WINDOW_TICKS_0:  window_ticks_0  <= cfg_data[fwrl_pkg::WIN_W-1:0];
        fwrl_pkg::CFG_MAX_COUNT_1:     max_count_1     <= cfg_data[fwrl_pkg::CNT_W-1:0];
        fwrl_pkg::CFG_WINDOW_TICKS_1:  window_ticks_1  <= cfg_data[fwrl_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req  <= s_tuser[fwrl_pkg::REQ_W-1:0];
      rule <= s_tuser[fwrl_pkg::REQ_W +: fwrl_pkg::RULE_W];
      key  <= s_tdata[fwrl_pkg::KEY_W-1:0];
    end
  end

  // rule, index and window decode
  always_comb begin
    enabled = !limiter_off && (32'(rule) < fwrl_pkg::RULE_TYPES) && rule_registered[rule];
    key_ok  = 32'(key) < fwrl_pkg::KEYS_PER_RULE;
    idx     = fwrl_pkg::IDX_W'(32'(rule) * fwrl_pkg::KEYS_PER_RULE + 32'(key));
    act     = enabled && key_ok && (req == fwrl_pkg::REQ_CHECK || req == fwrl_pkg::REQ_CLEAR);
    maxc    = (rule == '0) ? max_count_0 : max_count_1;
    win     = (rule == '0) ? window_ticks_0 : window_ticks_1;
    age     = tick_now - ram_rdata.start;
  end

  // check and write-back decision
  always_comb begin
    limited         = 1'b0;
    ram_we          = 1'b0;
    ram_wdata.count = fwrl_pkg::CNT_W'(1);
    ram_wdata.start = tick_now;
    if (act && req == fwrl_pkg::REQ_CHECK) begin
      if (!entry_valid[idx]) begin
        ram_we = 1'b1;
      end else if (age < {1'b0, win}) begin
        if (ram_rdata.count >= maxc) begin
          limited = 1'b1;
        end else begin
          ram_we          = 1'b1;
          ram_wdata.count = ram_rdata.count + fwrl_pkg::CNT_W'(1);
          ram_wdata.start = ram_rdata.start;
        end
      end else begin
        // window expired: restart
        ram_we = 1'b1;
      end
    end
  end

  // entry store
  fwrl_ram #(
    .WIDTH(fwrl_pkg::ENTRY_W),
    .DEPTH(fwrl_pkg::ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.exec && ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // tick counter and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now    <= '0;
      entry_valid <= '0;
    end else if (cmd.exec) begin
      if (req == fwrl_pkg::REQ_TICK) begin
        tick_now <= tick_now + fwrl_pkg::TICK_W'(1);
      end
      if (act && req == fwrl_pkg::REQ_CLEAR) begin
        entry_valid[idx] <= 1'b0;
      end else if (act && req == fwrl_pkg::REQ_CHECK) begin
        entry_valid[idx] <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      limited_q <= limited;
      enabled_q <= enabled;
    end
  end

  assign m_tdata      = {6'd0, enabled_q, limited_q};
  assign sts.out_busy = m_tvalid && !m_tready;

  `FWRL_ASSERT_NEXT(a_exec_shows, clk, rst, cmd.exec, m_tvalid, "result not presented after exec")
  `FWRL_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped")
  `FWRL_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "result changed")

endmodule

@@ src/fixed_window_rate_limiter.sv @@
// Top level of the fixed-window rate limiter.
// Depends on fwrl_pkg, fwrl_ctrl, fwrl_dpath (and fwrl_ram below it).
//
//   channel | direction | tdata (low bit up)  | tuser (low bit up)
//   s_*     | in        | key_index[5:0]      | req_type[1:0], rule_type
//   m_*     | out       | limited, rule_enabled | -
//   cfg_*   | in        | cfg_data: register value, cfg_index: register number
//
// Each item goes from accept to result in these steps: accept, entry RAM read,
// check and write-back; the next item is taken in the cycle after that, so a new
// item waits until the last is through. The registered RAM read needs its own step.
// Reset clears the tick counter, the entry valid flops and the config at once.
// A result waiting in the output register stalls only the execute step.
module fixed_window_rate_limiter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // key_index[5:0], zero fill
  input  logic [2:0]                     s_tuser,   // req_type[1:0], rule_type[2]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // limited[0], rule_enabled[1], zero fill
  input  logic                           cfg_we,
  input  logic [fwrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fwrl_pkg::CFG_W-1:0]     cfg_data
);

  fwrl_pkg::cmd_t cmd;
  fwrl_pkg::sts_t sts;

  fwrl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  fwrl_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule
